// ===== design/tmn_pkg.sv =====
// ---------------------------------------------------------------------------
// Template match package
// Shared types and fixed constants of the normalized correlation matcher.
// ---------------------------------------------------------------------------
package tmn_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int PWR_W      = 11;
  localparam int PHR_W      = 10;
  localparam int TWR_W      = 9;
  localparam int THR_W      = 8;
  localparam int SCORE_W    = 16;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 9;
  localparam int QUO_W      = 33;
  localparam int ROOT_W     = 17;
  localparam int SREM_W     = 19;

  localparam logic [CFG_IDX_W-1:0] CFG_PATCH_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATCH_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPLATE_WIDTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPLATE_HEIGHT = 2'd3;

  localparam logic REQ_PATCH    = 1'b0;
  localparam logic REQ_TEMPLATE = 1'b1;

  localparam logic signed [SCORE_W-1:0] SCORE_LOWEST = 16'sh8000;
  localparam logic [SCORE_W-2:0]        SCORE_TOP    = 15'h7fff;

  typedef struct packed {
    logic             req_type;
    logic [PIX_W-1:0] pixel_value;
  } tmn_in_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] peak_score;
    logic [COL_W-1:0]          best_col;
    logic [ROW_W-1:0]          best_row;
  } tmn_out_t;

endpackage

// ===== design/template_match_ncc_maxloc.sv =====
// ---------------------------------------------------------------------------
// Template matcher with normalized cross-correlation
// Stores a patch and a template, scores every offset and reports the best.
// ---------------------------------------------------------------------------
//  channel | direction | handshake           | content
//  pixel   | in        | pixel_valid / stall | req_type, pixel_value
//  result  | out       | result_valid / stall| peak_score, best_col, best_row
//  cfg     | in        | cfg_valid / ready   | cfg_index, cfg_data
//
// Unless stalled, pixels load at one item per cycle into two-port stores.
// After the last template pixel the search first sums the template, then for
// each offset reads the window and scores it (scoring ends early when a
// variance term is zero); its pace is set by the one read port per store, the
// bit-serial multipliers and the 33-cell divider chain.
// Reset is synchronous; no clearing pass is needed. The pixel channel stalls
// during the search; a result still waiting when the next search ends holds
// the block until it is taken.
// ---------------------------------------------------------------------------
module template_match_ncc_maxloc
  import tmn_pkg::*;
#(
  parameter int MAX_PATCH_WIDTH     = 1024,
  parameter int MAX_PATCH_HEIGHT    = 512,
  parameter int MAX_TEMPLATE_WIDTH  = 256,
  parameter int MAX_TEMPLATE_HEIGHT = 128,
  parameter int MAX_RESULT_WIDTH    = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  tmn_in_t               pixel,
  output logic                  result_valid,
  input  logic                  result_stall,
  output tmn_out_t              result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PW_W   = $clog2(MAX_PATCH_WIDTH + 1);
  localparam int PH_W   = $clog2(MAX_PATCH_HEIGHT + 1);
  localparam int TW_W   = $clog2(MAX_TEMPLATE_WIDTH + 1);
  localparam int TH_W   = $clog2(MAX_TEMPLATE_HEIGHT + 1);
  localparam int DA_W   = (PW_W > PH_W) ? PW_W : PH_W;
  localparam int DB_W   = (TW_W > TH_W) ? TW_W : TH_W;
  localparam int DIM_W  = (DA_W > DB_W) ? DA_W : DB_W;
  localparam int PDEPTH = MAX_PATCH_WIDTH * MAX_PATCH_HEIGHT;
  localparam int PADR_W = $clog2(PDEPTH);
  localparam int PCNT_W = $clog2(PDEPTH + 1);
  localparam int TDEPTH = MAX_TEMPLATE_WIDTH * MAX_TEMPLATE_HEIGHT;
  localparam int TADR_W = $clog2(TDEPTH);
  localparam int N_W    = $clog2(TDEPTH + 1);
  localparam int S1_W   = N_W + PIX_W;
  localparam int S2_W   = N_W + 2 * PIX_W;
  localparam int A_W    = 2 * N_W + 2 * PIX_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_TSUM   = 7'b0000010,
    S_TPREP1 = 7'b0000100,
    S_TPREP2 = 7'b0001000,
    S_WIN    = 7'b0010000,
    S_SCORE  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state;

  logic [PWR_W-1:0] patch_width;
  logic [PHR_W-1:0] patch_height;
  logic [TWR_W-1:0] template_width;
  logic [THR_W-1:0] template_height;

  logic [DIM_W-1:0]  pw, ph, tw, th, rw_raw, rw, rh;
  logic              no_fit;
  logic [PCNT_W-1:0] ptarget;
  logic [N_W-1:0]    n;

  logic [PCNT_W-1:0] pcnt;
  logic [N_W-1:0]    tcnt, tcnt_inc;
  logic              pix_acc, is_patch, p_full, pwe, t_take, twe, go;

  logic [PIX_W-1:0] pmem [PDEPTH];
  logic [PIX_W-1:0] tmem [TDEPTH];
  logic [PIX_W-1:0] pdata, tdata;
  logic [PCNT_W-1:0] p_rd;

  logic [DIM_W-1:0]  u, v, dx, dy;
  logic [N_W-1:0]    taddr;
  logic [PCNT_W-1:0] vbase, ubase, rowaddr;
  logic              issued_all, issue, issue_last, rd_v, rd_last;

  logic [S1_W-1:0] st, ps;
  logic [S2_W-1:0] st2, cs, sq;
  logic [A_W-1:0]  stn, stsq, dt;
  logic [2*PIX_W-1:0] prod_tp, prod_pp, prod_tt;

  logic                      sc_start, sc_done;
  logic signed [SCORE_W-1:0] sc_score;
  logic signed [SCORE_W-1:0] best;
  logic [COL_W-1:0]          best_col;
  logic [ROW_W-1:0]          best_row;
  logic                      out_free;

  assign cfg_ready   = 1'b1;
  assign pixel_stall = (state != S_IDLE);

  always_comb begin
    pw = (patch_width == '0) ? DIM_W'(1) :
         (32'(patch_width) > MAX_PATCH_WIDTH) ? DIM_W'(MAX_PATCH_WIDTH) : DIM_W'(patch_width);
    ph = (patch_height == '0) ? DIM_W'(1) :
         (32'(patch_height) > MAX_PATCH_HEIGHT) ? DIM_W'(MAX_PATCH_HEIGHT) :
         DIM_W'(patch_height);
    tw = (template_width == '0) ? DIM_W'(1) :
         (32'(template_width) > MAX_TEMPLATE_WIDTH) ? DIM_W'(MAX_TEMPLATE_WIDTH) :
         DIM_W'(template_width);
    th = (template_height == '0) ? DIM_W'(1) :
         (32'(template_height) > MAX_TEMPLATE_HEIGHT) ? DIM_W'(MAX_TEMPLATE_HEIGHT) :
         DIM_W'(template_height);
    ptarget = PCNT_W'(pw) * PCNT_W'(ph);
    n       = N_W'(tw) * N_W'(th);
    no_fit  = (tw > pw) || (th > ph);
    rw_raw  = pw - tw + DIM_W'(1);
    rw      = (32'(rw_raw) > MAX_RESULT_WIDTH) ? DIM_W'(MAX_RESULT_WIDTH) : rw_raw;
    rh      = ph - th + DIM_W'(1);
  end

  always_comb begin
    pix_acc  = pixel_valid && !pixel_stall;
    is_patch = pixel.req_type == REQ_PATCH;
    p_full   = pcnt >= ptarget;
    pwe      = pix_acc && is_patch && !p_full;
    t_take   = pix_acc && !is_patch && p_full;
    twe      = t_take && (tcnt < n);
    tcnt_inc = tcnt + N_W'(twe);
    go       = t_take && (tcnt_inc >= n);
  end

  always_comb begin
    issue      = ((state == S_WIN) || (state == S_TSUM)) && !issued_all;
    issue_last = (state == S_TSUM) ? (taddr == n - N_W'(1)) :
                 ((dx == tw - DIM_W'(1)) && (dy == th - DIM_W'(1)));
    p_rd       = rowaddr + PCNT_W'(dx);
    prod_tp    = (2*PIX_W)'(tdata) * (2*PIX_W)'(pdata);
    prod_pp    = (2*PIX_W)'(pdata) * (2*PIX_W)'(pdata);
    prod_tt    = (2*PIX_W)'(tdata) * (2*PIX_W)'(tdata);
    out_free   = !result_valid || !result_stall;
  end

  always_ff @(posedge clk) begin
    if (pwe) begin
      pmem[pcnt[PADR_W-1:0]] <= pixel.pixel_value;
    end
    pdata <= pmem[p_rd[PADR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (twe) begin
      tmem[tcnt[TADR_W-1:0]] <= pixel.pixel_value;
    end
    tdata <= tmem[taddr[TADR_W-1:0]];
  end

  tmn_score #(
    .N_W(N_W)
  ) u_score (
    .clk   (clk),
    .rst   (rst),
    .start (sc_start),
    .n     (n),
    .st    (st),
    .dt    (dt),
    .cs    (cs),
    .sq    (sq),
    .ps    (ps),
    .done  (sc_done),
    .score (sc_score)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      patch_width     <= PWR_W'(1);
      patch_height    <= PHR_W'(1);
      template_width  <= TWR_W'(1);
      template_height <= THR_W'(1);
      pcnt            <= '0;
      tcnt            <= '0;
      issued_all      <= 1'b0;
      rd_v            <= 1'b0;
      rd_last         <= 1'b0;
      sc_start        <= 1'b0;
      best            <= SCORE_LOWEST;
      best_col        <= '0;
      best_row        <= '0;
      result_valid    <= 1'b0;
    end else begin
      sc_start <= 1'b0;
      rd_v     <= issue;
      rd_last  <= issue && issue_last;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PATCH_WIDTH:     patch_width     <= cfg_data[PWR_W-1:0];
          CFG_PATCH_HEIGHT:    patch_height    <= cfg_data[PHR_W-1:0];
          CFG_TEMPLATE_WIDTH:  template_width  <= cfg_data[TWR_W-1:0];
          CFG_TEMPLATE_HEIGHT: template_height <= cfg_data[THR_W-1:0];
          default: begin
          end
        endcase
      end

      if (issue) begin
        taddr <= taddr + N_W'(1);
        if (dx == tw - DIM_W'(1)) begin
          dx      <= '0;
          dy      <= dy + DIM_W'(1);
          rowaddr <= rowaddr + PCNT_W'(pw);
        end else begin
          dx <= dx + DIM_W'(1);
        end
        if (issue_last) begin
          issued_all <= 1'b1;
        end
      end

      if (rd_v) begin
        if (state == S_TSUM) begin
          st  <= st + S1_W'(tdata);
          st2 <= st2 + S2_W'(prod_tt);
        end else begin
          cs <= cs + S2_W'(prod_tp);
          sq <= sq + S2_W'(prod_pp);
          ps <= ps + S1_W'(pdata);
        end
      end

      if (state == S_DONE && out_free) begin
        result_valid      <= 1'b1;
        result.peak_score <= best;
        result.best_col   <= best_col;
        result.best_row   <= best_row;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (pwe) begin
            pcnt <= pcnt + PCNT_W'(1);
          end
          if (go) begin
            pcnt       <= '0;
            tcnt       <= '0;
            taddr      <= '0;
            issued_all <= 1'b0;
            st         <= '0;
            st2        <= '0;
            best       <= SCORE_LOWEST;
            best_col   <= '0;
            best_row   <= '0;
            state      <= S_TSUM;
          end else begin
            tcnt <= tcnt_inc;
          end
        end
        S_TSUM: begin
          if (rd_v && rd_last) begin
            state <= S_TPREP1;
          end
        end
        S_TPREP1: begin
          stn   <= A_W'(n) * A_W'(st2);
          stsq  <= A_W'(st) * A_W'(st);
          state <= S_TPREP2;
        end
        S_TPREP2: begin
          dt <= (stn >= stsq) ? stn - stsq : '0;
          if (no_fit) begin
            state <= S_DONE;
          end else begin
            u          <= '0;
            v          <= '0;
            vbase      <= '0;
            ubase      <= '0;
            rowaddr    <= '0;
            dx         <= '0;
            dy         <= '0;
            taddr      <= '0;
            issued_all <= 1'b0;
            cs         <= '0;
            sq         <= '0;
            ps         <= '0;
            state      <= S_WIN;
          end
        end
        S_WIN: begin
          if (rd_v && rd_last) begin
            sc_start <= 1'b1;
            state    <= S_SCORE;
          end
        end
        S_SCORE: begin
          if (sc_done) begin
            if (sc_score > best) begin
              best     <= sc_score;
              best_col <= COL_W'(u);
              best_row <= ROW_W'(v);
            end
            dx         <= '0;
            dy         <= '0;
            taddr      <= '0;
            issued_all <= 1'b0;
            cs         <= '0;
            sq         <= '0;
            ps         <= '0;
            if (u == rw - DIM_W'(1)) begin
              if (v == rh - DIM_W'(1)) begin
                state <= S_DONE;
              end else begin
                u       <= '0;
                v       <= v + DIM_W'(1);
                vbase   <= vbase + PCNT_W'(pw);
                ubase   <= vbase + PCNT_W'(pw);
                rowaddr <= vbase + PCNT_W'(pw);
                state   <= S_WIN;
              end
            end else begin
              u       <= u + DIM_W'(1);
              ubase   <= ubase + PCNT_W'(1);
              rowaddr <= ubase + PCNT_W'(1);
              state   <= S_WIN;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/tmn_div_cell.sv =====
// ---------------------------------------------------------------------------
// Divider cell
// One restoring division step; cells are chained to form the quotient.
// ---------------------------------------------------------------------------
module tmn_div_cell
  import tmn_pkg::*;
#(
  parameter int R_W = 96
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             left_valid,
  input  logic [R_W-1:0]   left_rem,
  input  logic [R_W-1:0]   left_den,
  input  logic [QUO_W-1:0] left_dvd,
  input  logic [QUO_W-1:0] left_quo,
  output logic             right_valid,
  output logic [R_W-1:0]   right_rem,
  output logic [R_W-1:0]   right_den,
  output logic [QUO_W-1:0] right_dvd,
  output logic [QUO_W-1:0] right_quo
);

  logic [R_W:0] trial;
  logic [R_W:0] diff;
  logic         fits;

  always_comb begin
    trial = {left_rem, left_dvd[QUO_W-1]};
    fits  = trial >= {1'b0, left_den};
    diff  = trial - {1'b0, left_den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      right_valid <= 1'b0;
    end else begin
      right_valid <= left_valid;
    end
  end

  always_ff @(posedge clk) begin
    right_rem <= fits ? diff[R_W-1:0] : trial[R_W-1:0];
    right_den <= left_den;
    right_dvd <= {left_dvd[QUO_W-2:0], 1'b0};
    right_quo <= {left_quo[QUO_W-2:0], fits};
  end

endmodule

// ===== design/tmn_score.sv =====
// ---------------------------------------------------------------------------
// Score unit
// Turns window sums into a signed Q1.15 correlation score, exactly rounded.
// ---------------------------------------------------------------------------
module tmn_score
  import tmn_pkg::*;
#(
  parameter int N_W = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [N_W-1:0]            n,
  input  logic [N_W+PIX_W-1:0]      st,
  input  logic [2*N_W+2*PIX_W-1:0]  dt,
  input  logic [N_W+2*PIX_W-1:0]    cs,
  input  logic [N_W+2*PIX_W-1:0]    sq,
  input  logic [N_W+PIX_W-1:0]      ps,
  output logic                      done,
  output logic signed [SCORE_W-1:0] score
);

  localparam int A_W   = 2 * N_W + 2 * PIX_W;
  localparam int R_W   = 2 * A_W;
  localparam int CNT_W = $clog2(A_W);

  typedef enum logic [6:0] {
    P_IDLE = 7'b0000001,
    P_DIFF = 7'b0000010,
    P_CHK  = 7'b0000100,
    P_MULS = 7'b0001000,
    P_DIV  = 7'b0010000,
    P_SQRT = 7'b0100000,
    P_FIN  = 7'b1000000
  } score_state_t;

  score_state_t state;
  logic [A_W-1:0]   x, y, sin, sisq, di, a;
  logic             pos;
  logic [R_W-1:0]   mca, mcd, acca, accd;
  logic [A_W-1:0]   mpa, mpd;
  logic [CNT_W-1:0] cnt;
  logic             div_go;
  logic [QUO_W:0]   qsh;
  logic [SREM_W-1:0] rem;
  logic [ROOT_W-1:0] root;
  logic [SREM_W+1:0] rem4;
  logic [SREM_W+1:0] sq_trial;
  logic [ROOT_W:0]   root_p1;
  logic [ROOT_W-1:0] qq;
  logic [SCORE_W-2:0] qsat;

  logic             cv   [QUO_W+1];
  logic [R_W-1:0]   crem [QUO_W+1];
  logic [R_W-1:0]   cden [QUO_W+1];
  logic [QUO_W-1:0] cdvd [QUO_W+1];
  logic [QUO_W-1:0] cquo [QUO_W+1];

  always_comb begin
    cv[0]   = div_go;
    crem[0] = acca >> 1;
    cden[0] = accd;
    cdvd[0] = {acca[0], (QUO_W-1)'(0)};
    cquo[0] = '0;
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    tmn_div_cell #(
      .R_W(R_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .left_valid  (cv[k]),
      .left_rem    (crem[k]),
      .left_den    (cden[k]),
      .left_dvd    (cdvd[k]),
      .left_quo    (cquo[k]),
      .right_valid (cv[k+1]),
      .right_rem   (crem[k+1]),
      .right_den   (cden[k+1]),
      .right_dvd   (cdvd[k+1]),
      .right_quo   (cquo[k+1])
    );
  end

  always_comb begin
    rem4     = {rem, qsh[QUO_W:QUO_W-1]};
    sq_trial = (SREM_W+2)'({root, 2'b01});
    root_p1  = (ROOT_W+1)'(root) + (ROOT_W+1)'(1);
    qq       = root_p1[ROOT_W:1];
    qsat     = (qq > ROOT_W'(SCORE_TOP)) ? SCORE_TOP : qq[SCORE_W-2:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= P_IDLE;
      done   <= 1'b0;
      div_go <= 1'b0;
    end else begin
      done   <= 1'b0;
      div_go <= 1'b0;
      case (state)
        P_IDLE: begin
          if (start) begin
            x     <= A_W'(n) * A_W'(cs);
            y     <= A_W'(st) * A_W'(ps);
            sin   <= A_W'(n) * A_W'(sq);
            sisq  <= A_W'(ps) * A_W'(ps);
            state <= P_DIFF;
          end
        end
        P_DIFF: begin
          di    <= (sin >= sisq) ? sin - sisq : '0;
          pos   <= x >= y;
          a     <= (x >= y) ? x - y : y - x;
          state <= P_CHK;
        end
        P_CHK: begin
          if (di == '0 || dt == '0) begin
            score <= '0;
            done  <= 1'b1;
            state <= P_IDLE;
          end else begin
            mca   <= R_W'(a);
            mpa   <= a;
            acca  <= '0;
            mcd   <= R_W'(dt);
            mpd   <= di;
            accd  <= '0;
            cnt   <= '0;
            state <= P_MULS;
          end
        end
        P_MULS: begin
          if (mpa[0]) begin
            acca <= acca + mca;
          end
          if (mpd[0]) begin
            accd <= accd + mcd;
          end
          mca <= mca << 1;
          mcd <= mcd << 1;
          mpa <= mpa >> 1;
          mpd <= mpd >> 1;
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(A_W - 1)) begin
            div_go <= 1'b1;
            state  <= P_DIV;
          end
        end
        P_DIV: begin
          if (cv[QUO_W]) begin
            qsh   <= {1'b0, cquo[QUO_W]};
            rem   <= '0;
            root  <= '0;
            cnt   <= '0;
            state <= P_SQRT;
          end
        end
        P_SQRT: begin
          if (rem4 >= sq_trial) begin
            rem  <= SREM_W'(rem4 - sq_trial);
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            rem  <= rem4[SREM_W-1:0];
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          qsh <= {qsh[QUO_W-2:0], 2'b00};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(ROOT_W - 1)) begin
            state <= P_FIN;
          end
        end
        P_FIN: begin
          score <= pos ? SCORE_W'(qsat) : -SCORE_W'(qsat);
          done  <= 1'b1;
          state <= P_IDLE;
        end
        default: begin
          state <= P_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/template_match_ncc_maxloc_test.sv =====
// ---------------------------------------------------------------------------
// Template matcher testbench
// Loads patches and templates of many shapes and contents, predicts the best
// normalized correlation score and position of each frame with exact integer
// arithmetic, and checks every result as it leaves the block under random
// idle cycles and stalls on both sides.
// ---------------------------------------------------------------------------
module template_match_ncc_maxloc_test;
  import tmn_pkg::*;

  localparam int LIM_PW = 1024;
  localparam int LIM_PH = 512;
  localparam int LIM_TW = 256;
  localparam int LIM_TH = 128;
  localparam int LIM_RW = 1024;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  pixel_valid = 1'b0;
  logic                  pixel_stall;
  tmn_in_t               pixel = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  tmn_out_t              result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_PATCH_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  template_match_ncc_maxloc uut (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [7:0]  patch_mem [LIM_PW*LIM_PH];
  logic [7:0]  tmpl_mem [LIM_TW*LIM_TH];
  int unsigned patch_count, tmpl_count;
  logic [10:0] reg_pw = 11'd1;
  logic [9:0]  reg_ph = 10'd1;
  logic [8:0]  reg_tw = 9'd1;
  logic [7:0]  reg_th = 8'd1;

  tmn_out_t    best_queue[$];
  int          errors = 0;
  int          pixels_sent = 0;
  int          frames_checked = 0;
  bit          quiet_sender = 1'b0;
  bit          quiet_receiver = 1'b0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic int unsigned score_mag(longint unsigned a, longint unsigned dt,
                                            longint unsigned di);
    logic [255:0] prod, rhs, m;
    int unsigned lo, hi, mid;
    prod = {192'd0, dt} * {192'd0, di};
    rhs = ({192'd0, a} * {192'd0, a}) << 32;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      m = 256'(2 * mid - 1);
      if (prod * m * m <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return (lo > 32767) ? 32767 : lo;
  endfunction

  function automatic tmn_out_t search_best();
    int unsigned pw, ph, tw, th, rw, rh, u, v, dx, dy, q;
    longint unsigned n, ts, tq, dt, cs, sq, ps, p, t, x, y, sn, ss, di, st2n, stsq;
    int signed score;
    tmn_out_t r;
    pw = clamp_dim(reg_pw, LIM_PW);
    ph = clamp_dim(reg_ph, LIM_PH);
    tw = clamp_dim(reg_tw, LIM_TW);
    th = clamp_dim(reg_th, LIM_TH);
    n = tw * th;
    r.peak_score = SCORE_LOWEST;
    r.best_col = '0;
    r.best_row = '0;
    ts = 0;
    tq = 0;
    for (int i = 0; i < n; i++) begin
      ts += tmpl_mem[i];
      tq += tmpl_mem[i] * tmpl_mem[i];
    end
    if (tw > pw || th > ph) return r;
    rw = pw - tw + 1;
    if (rw > LIM_RW) rw = LIM_RW;
    rh = ph - th + 1;
    st2n = n * tq;
    stsq = ts * ts;
    dt = (st2n >= stsq) ? st2n - stsq : 0;
    for (v = 0; v < rh; v++) begin
      for (u = 0; u < rw; u++) begin
        cs = 0;
        sq = 0;
        ps = 0;
        for (dy = 0; dy < th; dy++) begin
          for (dx = 0; dx < tw; dx++) begin
            p = patch_mem[(v + dy) * pw + u + dx];
            t = tmpl_mem[dy * tw + dx];
            cs += t * p;
            sq += p * p;
            ps += p;
          end
        end
        x = n * cs;
        y = ts * ps;
        sn = n * sq;
        ss = ps * ps;
        di = (sn >= ss) ? sn - ss : 0;
        score = 0;
        if (di != 0 && dt != 0) begin
          q = score_mag((x >= y) ? x - y : y - x, dt, di);
          score = (x >= y) ? int'(q) : -int'(q);
        end
        if (score > int'(r.peak_score)) begin
          r.peak_score = SCORE_W'(score);
          r.best_col = COL_W'(u);
          r.best_row = ROW_W'(v);
        end
      end
    end
    return r;
  endfunction

  function automatic void predict_pixel(tmn_in_t it);
    int unsigned ptarget, ttarget;
    ptarget = clamp_dim(reg_pw, LIM_PW) * clamp_dim(reg_ph, LIM_PH);
    ttarget = clamp_dim(reg_tw, LIM_TW) * clamp_dim(reg_th, LIM_TH);
    if (it.req_type == REQ_PATCH) begin
      if (patch_count < ptarget) begin
        patch_mem[patch_count] = it.pixel_value;
        patch_count++;
      end
      return;
    end
    if (patch_count < ptarget) return;
    if (tmpl_count < ttarget) begin
      tmpl_mem[tmpl_count] = it.pixel_value;
      tmpl_count++;
    end
    if (tmpl_count < ttarget) return;
    best_queue.push_back(search_best());
    patch_count = 0;
    tmpl_count = 0;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    if (quiet_receiver) result_stall <= 1'b0;
    else result_stall <= (gap_len() != 0);
  end

  always @(negedge clk) begin
    tmn_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (best_queue.size() == 0) begin
        report_mismatch("unexpected result score", result.peak_score, 0);
      end else begin
        want = best_queue.pop_front();
        if (result.peak_score !== want.peak_score)
          report_mismatch("peak_score", result.peak_score, want.peak_score);
        if (result.best_col !== want.best_col)
          report_mismatch("best_col", result.best_col, want.best_col);
        if (result.best_row !== want.best_row)
          report_mismatch("best_row", result.best_row, want.best_row);
        frames_checked++;
      end
    end
  end

  task automatic send_pixel(logic kind, logic [7:0] value);
    tmn_in_t it;
    bit taken;
    int g;
    it.req_type = kind;
    it.pixel_value = value;
    predict_pixel(it);
    pixel <= it;
    pixel_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = !pixel_stall;
      @(posedge clk);
    end while (!taken);
    pixels_sent++;
    g = quiet_sender ? 0 : gap_len();
    if (g != 0) begin
      pixel_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    pixel_valid <= 1'b0;
    while (best_queue.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    bit taken;
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_PATCH_WIDTH:  reg_pw = value[10:0];
      CFG_PATCH_HEIGHT: reg_ph = value[9:0];
      CFG_TEMPLATE_WIDTH: reg_tw = value[8:0];
      default:          reg_th = value[7:0];
    endcase
  endtask

  task automatic set_dims(int pw, int ph, int tw, int th);
    wait_drained();
    write_reg(CFG_PATCH_WIDTH, CFG_DATA_W'(pw));
    write_reg(CFG_PATCH_HEIGHT, CFG_DATA_W'(ph));
    write_reg(CFG_TEMPLATE_WIDTH, CFG_DATA_W'(tw));
    write_reg(CFG_TEMPLATE_HEIGHT, CFG_DATA_W'(th));
  endtask

  // Content styles: 0 random, 1 copy of a patch window, 2 inverted copy,
  // 3 flat template, 4 flat patch, 5 low contrast.
  task automatic run_frame(int pw, int ph, int tw, int th, int style, bit noise);
    int unsigned epw, eph, etw, eth, ou, ov, base;
    logic [7:0] img[];
    logic [7:0] tv;
    epw = clamp_dim(pw, LIM_PW);
    eph = clamp_dim(ph, LIM_PH);
    etw = clamp_dim(tw, LIM_TW);
    eth = clamp_dim(th, LIM_TH);
    set_dims(pw, ph, tw, th);
    img = new[epw * eph];
    base = $urandom_range(0, 250);
    foreach (img[i]) begin
      if (style == 4) img[i] = 8'(base);
      else if (style == 5) img[i] = 8'(base + $urandom_range(0, 2));
      else img[i] = 8'($urandom_range(0, 255));
    end
    if (noise) send_pixel(REQ_TEMPLATE, 8'($urandom_range(0, 255)));
    foreach (img[i]) send_pixel(REQ_PATCH, img[i]);
    if (noise) send_pixel(REQ_PATCH, 8'($urandom_range(0, 255)));
    ou = (etw <= epw) ? $urandom_range(0, epw - etw) : 0;
    ov = (eth <= eph) ? $urandom_range(0, eph - eth) : 0;
    for (int y = 0; y < eth; y++) begin
      for (int x = 0; x < etw; x++) begin
        if ((style == 1 || style == 2) && etw <= epw && eth <= eph) begin
          tv = img[(ov + y) * epw + ou + x];
          if (style == 2) tv = 8'd255 - tv;
        end else if (style == 3) begin
          tv = 8'(base);
        end else begin
          tv = 8'($urandom_range(0, 255));
        end
        send_pixel(REQ_TEMPLATE, tv);
      end
    end
  endtask

  task automatic test_reset_dims();
    send_pixel(REQ_PATCH, 8'd0);
    send_pixel(REQ_TEMPLATE, 8'd255);
  endtask

  task automatic test_matches();
    run_frame(4, 3, 2, 2, 1, 1'b0);
    run_frame(4, 3, 2, 2, 2, 1'b0);
    run_frame(3, 3, 2, 2, 0, 1'b0);
  endtask

  task automatic test_flat_cases();
    run_frame(3, 3, 2, 1, 3, 1'b0);
    run_frame(3, 2, 2, 2, 4, 1'b0);
  endtask

  task automatic test_oversize_template();
    run_frame(0, 2, 3, 1, 0, 1'b0);
  endtask

  task automatic test_ignored_pixels();
    run_frame(3, 2, 2, 1, 1, 1'b1);
  endtask

  task automatic test_shrunk_template();
    set_dims(3, 3, 2, 2);
    for (int i = 0; i < 9; i++) send_pixel(REQ_PATCH, 8'($urandom_range(0, 255)));
    send_pixel(REQ_TEMPLATE, 8'd10);
    send_pixel(REQ_TEMPLATE, 8'd200);
    pixel_valid <= 1'b0;
    repeat (60) @(posedge clk);
    write_reg(CFG_TEMPLATE_HEIGHT, '0);
    send_pixel(REQ_TEMPLATE, 8'd77);
  endtask

  task automatic test_register_extremes();
    run_frame(1, 1023, 1, 2, 0, 1'b0);
    run_frame(1, 1, 511, 1, 0, 1'b0);
    run_frame(1, 1, 1, 255, 0, 1'b0);
  endtask

  task automatic test_random_frames();
    int pw, ph, tw, th;
    while (pixels_sent < 1400) begin
      quiet_sender = ($urandom_range(0, 5) == 0);
      quiet_receiver = ($urandom_range(0, 5) == 0);
      pw = $urandom_range(0, 9);
      ph = $urandom_range(0, 6);
      tw = $urandom_range(0, 4);
      th = $urandom_range(0, 3);
      run_frame(pw, ph, tw, th, $urandom_range(0, 5), $urandom_range(0, 19) == 0);
      if ($urandom_range(0, 3) == 0)
        wait_drained();
    end
    quiet_sender = 1'b0;
    quiet_receiver = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_dims();
    test_matches();
    test_flat_cases();
    test_oversize_template();
    test_ignored_pixels();
    test_shrunk_template();
    test_register_extremes();
    test_random_frames();
    pixel_valid <= 1'b0;
    while (best_queue.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Sent %0d pixels and checked %0d frame results,", pixels_sent, frames_checked);
    $display("covering flat, matched, inverted, oversized and clamped shapes.");
    if (errors == 0) $display("[template_match_ncc_maxloc] OK");
    else $display("[template_match_ncc_maxloc] ERROR");
    $finish;
  end

  initial begin
    #80000000;
    $display("[template_match_ncc_maxloc] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
design/tmn_pkg.sv
design/tmn_div_cell.sv
design/tmn_score.sv
design/template_match_ncc_maxloc.sv
tb/template_match_ncc_maxloc_test.sv
